/* rtl/sha1md_pkg.sv */
// Shared types and constants for the SHA-1 message digest block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sha1md_pkg;

	// Round count, the byte position where the length field begins, and the padding marker byte.
	localparam int unsigned ROUND_COUNT = 80;
	localparam logic [6:0] ROUND_LAST = 7'(ROUND_COUNT - 1);
	localparam logic [5:0] LENGTH_POS = 6'd56;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Round constants, one for each group of twenty rounds.
	localparam logic [31:0] K_CH  = 32'h5a827999;
	localparam logic [31:0] K_P1  = 32'h6ed9eba1;
	localparam logic [31:0] K_MAJ = 32'h8f1bbcdc;
	localparam logic [31:0] K_P2  = 32'hca62c1d6;

	// Initial chaining words; element 0 is the most significant digest word.
	localparam logic [4:0][31:0] CHAIN_IV = {
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	// Where the sequencer goes once a compression has been folded in.
	typedef enum logic [1:0] {
		NX_IDLE,
		NX_PAD,
		NX_OUT
	} next_t;

	// Controls for the block store and message schedule.
	typedef struct packed {
		logic       wr_byte;
		logic       wr_len;
		logic       shift;
		logic [5:0] byte_pos;
		logic [7:0] byte_val;
	} sched_ctrl_t;

	// Controls for the round unit.
	typedef struct packed {
		logic load;
		logic step;
	} round_ctrl_t;

endpackage

`default_nettype wire

/* rtl/sha1md_sched.sv */
// Sixteen-word block store that doubles as the SHA-1 message schedule.
// Depends on sha1md_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module sha1md_sched (
	input  wire                       clk,
	input  sha1md_pkg::sched_ctrl_t   ctrl,
	input  wire  [63:0]               length_bits,
	output logic [31:0]               sched_word
);
	import sha1md_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] cur_word;
	logic [31:0] merged_word;
	logic [31:0] next_word;
	logic [3:0]  word_idx;

	assign word_idx = ctrl.byte_pos[5:2];
	assign cur_word = w_q[word_idx];

	// Merge the byte into its big-endian lane; the first lane replaces the word.
	always_comb begin
		case (ctrl.byte_pos[1:0])
			2'd0: merged_word = {ctrl.byte_val, 24'h000000};
			2'd1: merged_word = {cur_word[31:24], ctrl.byte_val, cur_word[15:0]};
			2'd2: merged_word = {cur_word[31:16], ctrl.byte_val, cur_word[7:0]};
			2'd3: merged_word = {cur_word[31:8], ctrl.byte_val};
			default: merged_word = cur_word;
		endcase
	end

	// Next schedule word from the fixed taps of the shift line.
	always_comb begin
		next_word = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		next_word = {next_word[30:0], next_word[31]};
	end

	assign sched_word = w_q[0];

	// Byte writes, length writes and the per-round shift.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= next_word;
		end else if (ctrl.wr_len) begin
			w_q[14] <= length_bits[63:32];
			w_q[15] <= length_bits[31:0];
		end else if (ctrl.wr_byte) begin
			w_q[word_idx] <= merged_word;
		end
	end

endmodule

`default_nettype wire

/* rtl/sha1md_round.sv */
// SHA-1 round unit: working words a..e and the shared round adder.
// Depends on sha1md_pkg for round constants and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module sha1md_round (
	input  wire                       clk,
	input  sha1md_pkg::round_ctrl_t   ctrl,
	input  wire  [4:0][31:0]          chain,
	input  wire  [31:0]               sched_word,
	input  wire  [6:0]                round_idx,
	output logic [4:0][31:0]          words
);
	import sha1md_pkg::*;

	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] tmp;

	// Logic function and constant for the current group of rounds.
	always_comb begin
		if (round_idx < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_CH;
		end else if (round_idx < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_P1;
		end else if (round_idx < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_MAJ;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_P2;
		end
	end

	assign tmp = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + sched_word;

	// Load from the chaining words, then one round per step.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= chain[0];
			b_q <= chain[1];
			c_q <= chain[2];
			d_q <= chain[3];
			e_q <= chain[4];
		end else if (ctrl.step) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign words = {e_q, d_q, c_q, b_q, a_q};

endmodule

`default_nettype wire

/* rtl/sha1_message_digest.sv */
// SHA-1 message digest, one message byte per request.
// A byte request is taken while ready is high; the 64th byte of a block holds ready low
// through the 80 rounds in the shared round unit and the chaining add.
// A closing request pads one byte per cycle (pausing while a filled block is compressed),
// writes the length, compresses once or twice in all, then shows five digest words.
// Reset loads the initial chaining words and clears the fill and length counters.
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_digest (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  data_byte,
	input  wire         byte_present,
	input  wire         last,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha1md_pkg::*;

	state_t          state_q, state_d;
	next_t           after_q, after_d;
	logic            pad_first_q, pad_first_d;
	logic [5:0]      fill_q, fill_d, fill_inc;
	logic [63:0]     len_q, len_d;
	logic [6:0]      round_q, round_d;
	logic [2:0]      widx_q, widx_d;
	logic [4:0][31:0] chain_q;
	logic            chain_iv, chain_add;
	sched_ctrl_t     sctl;
	round_ctrl_t     rctl;
	logic [31:0]     sched_word;
	logic [4:0][31:0] round_words;

	assign fill_inc = fill_q + 6'd1;

	sha1md_sched u_sched (
		.clk         (clk),
		.ctrl        (sctl),
		.length_bits (len_q),
		.sched_word  (sched_word)
	);

	sha1md_round u_round (
		.clk        (clk),
		.ctrl       (rctl),
		.chain      (chain_q),
		.sched_word (sched_word),
		.round_idx  (round_q),
		.words      (round_words)
	);

	// Sequencer: next state and controls.
	always_comb begin
		state_d     = state_q;
		after_d     = after_q;
		pad_first_d = pad_first_q;
		fill_d      = fill_q;
		len_d       = len_q;
		round_d     = round_q;
		widx_d      = widx_q;
		chain_iv    = 1'b0;
		chain_add   = 1'b0;
		sctl        = '0;
		sctl.byte_pos = fill_q;
		rctl        = '0;
		in_ready    = (state_q == ST_IDLE);
		out_valid   = (state_q == ST_OUT);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (last) begin
						pad_first_d = 1'b1;
					end
					if (byte_present) begin
						sctl.wr_byte  = 1'b1;
						sctl.byte_val = data_byte;
						fill_d        = fill_inc;
						len_d         = len_q + 64'd8;
						if (fill_inc == 6'd0) begin
							state_d   = ST_ROUND;
							rctl.load = 1'b1;
							round_d   = '0;
							after_d   = last ? NX_PAD : NX_IDLE;
						end else if (last) begin
							state_d = ST_PAD;
						end
					end else if (last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				// The marker byte first, then zeros up to the length field.
				sctl.wr_byte  = 1'b1;
				sctl.byte_val = pad_first_q ? PAD_BYTE : 8'h00;
				pad_first_d   = 1'b0;
				fill_d        = fill_inc;
				if (fill_inc == 6'd0) begin
					state_d   = ST_ROUND;
					rctl.load = 1'b1;
					round_d   = '0;
					after_d   = NX_PAD;
				end else if (fill_inc == LENGTH_POS) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				sctl.wr_len = 1'b1;
				fill_d      = '0;
				state_d     = ST_ROUND;
				rctl.load   = 1'b1;
				round_d     = '0;
				after_d     = NX_OUT;
			end
			ST_ROUND: begin
				rctl.step  = 1'b1;
				sctl.shift = 1'b1;
				round_d    = round_q + 7'd1;
				if (round_q == ROUND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				chain_add = 1'b1;
				case (after_q)
					NX_IDLE: state_d = ST_IDLE;
					NX_PAD:  state_d = ST_PAD;
					NX_OUT: begin
						state_d = ST_OUT;
						widx_d  = '0;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_OUT: begin
				if (out_ready) begin
					if (widx_q == 3'd4) begin
						chain_iv = 1'b1;
						fill_d   = '0;
						len_d    = '0;
						state_d  = ST_IDLE;
					end else begin
						widx_d = widx_q + 3'd1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_q     <= NX_IDLE;
			pad_first_q <= 1'b0;
			fill_q      <= '0;
			len_q       <= '0;
			round_q     <= '0;
			widx_q      <= '0;
		end else begin
			after_q     <= after_d;
			pad_first_q <= pad_first_d;
			fill_q      <= fill_d;
			len_q       <= len_d;
			round_q     <= round_d;
			widx_q      <= widx_d;
		end
	end

	// Chaining words: initial values after reset and after each digest, summed after each compression.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= CHAIN_IV;
		end else if (chain_iv) begin
			chain_q <= CHAIN_IV;
		end else if (chain_add) begin
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= chain_q[i] + round_words[i];
			end
		end
	end

	// Digest output straight from the chaining registers.
	assign digest_word = chain_q[widx_q];
	assign word_index  = widx_q;
	assign last_word   = (widx_q == 3'd4);

	// The round counter stays within the eighty rounds.
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q <= ROUND_LAST))
		else $error("round counter out of range");

	// A digest word index never passes the fifth word.
	a_widx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (widx_q <= 3'd4))
		else $error("digest word index out of range");

	// A plain byte that does not fill the block leaves the block ready.
	a_byte_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && byte_present && !last && fill_q != 6'd63) |=> in_ready)
		else $error("block not ready after a plain byte");

	// Taking the last digest word returns to idle with a fresh message.
	a_digest_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> (in_ready && fill_q == 6'd0
			&& len_q == 64'd0 && chain_q == CHAIN_IV))
		else $error("state not restored after digest");

endmodule

`default_nettype wire
